// ===== hw/rtl/change_dispense_with_stock_top_defines.svh =====
// Assertion macros used by the change dispenser RTL.
// Included by the top level only; depends on nothing else.
`ifndef CHANGE_DISPENSE_WITH_STOCK_TOP_DEFINES_SVH
`define CHANGE_DISPENSE_WITH_STOCK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDWS_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDWS_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cdws_pkg.sv =====
// Shared types, codes and face value tables of the change dispenser.
// Used by the controller, the datapath and the top level; no dependencies.
package cdws_pkg;

  localparam int KNOWN_NOTES  = 6;
  localparam int FACE_BITS    = 15;
  localparam int COUNT_BITS   = 24;
  localparam int STOCK_BITS   = 8;

  // Note counts come from a multiply by a scaled reciprocal of the face value.
  // With a scale of 2^39 the quotient is exact for every change below 2^24.
  localparam int CHG_BITS    = 24;
  localparam int RECIP_BITS  = 31;
  localparam int RECIP_SHIFT = 39;
  localparam int PROD_BITS   = CHG_BITS + RECIP_BITS;
  // Largest quotient is (2^24 - 1) / 500, which needs 16 bits.
  localparam int Q_BITS      = 16;
  // A stock-sized count times the largest face value: 255 * 20000 needs 23 bits.
  localparam int QF_BITS     = 23;

  localparam logic [1:0] PIECE_NOTE = 2'd0;
  localparam logic [1:0] PIECE_COIN = 2'd1;
  localparam logic [1:0] PIECE_NONE = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_SHORT       = 2'd1;
  localparam logic [1:0] ST_STOCK_SHORT = 2'd2;
  localparam logic [1:0] ST_REFILLED    = 2'd3;

  localparam logic [FACE_BITS-1:0]  COIN_CENTS   = 15'd1;
  localparam logic [STOCK_BITS-1:0] STOCK_RESET  = 8'd2;
  localparam logic [STOCK_BITS-1:0] REFILL_RESET = 8'd5;

  typedef struct packed {
    logic       load;
    logic       refill;
    logic       walk_init;
    logic       div_step;
    logic       commit_init;
    logic       commit_step;
    logic       emit_status;
    logic [1:0] status;
    logic       emit_coin;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic short_pay;
    logic walk_last;
    logic rem_gt1;
    logic rem_one;
    logic any_took;
    logic commit_last;
  } sts_t;

  function automatic logic [FACE_BITS-1:0] note_face_f(input logic [2:0] k);
    logic [FACE_BITS-1:0] f;
    case (k)
      3'd0:    f = 15'd20000;
      3'd1:    f = 15'd10000;
      3'd2:    f = 15'd5000;
      3'd3:    f = 15'd2000;
      3'd4:    f = 15'd1000;
      3'd5:    f = 15'd500;
      default: f = 15'd0;
    endcase
    return f;
  endfunction

  // Rounded-up 2^39 / face value for each note kind.
  function automatic logic [RECIP_BITS-1:0] note_recip_f(input logic [2:0] k);
    logic [RECIP_BITS-1:0] m;
    case (k)
      3'd0:    m = 31'd27487791;
      3'd1:    m = 31'd54975582;
      3'd2:    m = 31'd109951163;
      3'd3:    m = 31'd274877907;
      3'd4:    m = 31'd549755814;
      3'd5:    m = 31'd1099511628;
      default: m = 31'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/cdws_ctrl.sv =====
// Controller state machine of the change dispenser.
// Depends on cdws_pkg for the command and status structs and result codes.
module cdws_ctrl import cdws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_DIV    = 6'b000100,
    S_JUDGE  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_COIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op) begin
          cmd.refill      = 1'b1;
          cmd.emit_status = 1'b1;
          cmd.status      = ST_REFILLED;
          state_nxt       = S_IDLE;
        end else if (sts.short_pay) begin
          cmd.emit_status = 1'b1;
          cmd.status      = ST_SHORT;
          state_nxt       = S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (sts.rem_gt1) begin
          cmd.emit_status = 1'b1;
          cmd.status      = ST_STOCK_SHORT;
          state_nxt       = S_IDLE;
        end else if (!sts.any_took && !sts.rem_one) begin
          // Exact payment: nothing to hand out.
          cmd.emit_status = 1'b1;
          cmd.status      = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          cmd.commit_init = 1'b1;
          state_nxt       = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        if (sts.commit_last) begin
          state_nxt = sts.rem_one ? S_COIN : S_IDLE;
        end
      end
      S_COIN: begin
        cmd.emit_coin = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/cdws_dp.sv =====
// Datapath of the change dispenser: note stock, reciprocal divider, result register.
// Depends on cdws_pkg; driven by cdws_ctrl through cmd_t and reports through sts_t.
module cdws_dp import cdws_pkg::*; #(
  parameter int NOTE_KINDS  = 6,
  parameter int AMOUNT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_op,
  input  logic [23:0]            in_price_cents,
  input  logic [23:0]            in_paid_cents,
  input  logic                   cfg_wr,
  input  logic [STOCK_BITS-1:0]  cfg_data,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  output logic [1:0]             out_piece_kind,
  output logic [FACE_BITS-1:0]   out_value_cents,
  output logic [COUNT_BITS-1:0]  out_piece_count,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  localparam int AW       = AMOUNT_BITS;
  localparam int IW       = (NOTE_KINDS > 1) ? $clog2(NOTE_KINDS) : 1;
  localparam int NK_USED  = (NOTE_KINDS < KNOWN_NOTES) ? NOTE_KINDS : KNOWN_NOTES;
  localparam logic [IW-1:0] LAST_IDX = IW'(NK_USED - 1);

  logic [31:0]           price_ext, paid_ext;
  logic [AW:0]           diff_full;
  logic                  op_r, short_r;
  logic [AW-1:0]         diff_r, rem_r;
  logic [Q_BITS-1:0]     q_r;
  logic                  ph_r;
  logic [IW-1:0]         idx_r;
  logic [NOTE_KINDS-1:0] took_r;
  logic [STOCK_BITS-1:0] take_r  [NOTE_KINDS];
  logic [STOCK_BITS-1:0] stock_r [NOTE_KINDS];
  logic [STOCK_BITS-1:0] refill_r;

  logic                  out_valid_r, out_last_r;
  logic [1:0]            out_kind_r, out_status_r;
  logic [FACE_BITS-1:0]  out_value_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic [FACE_BITS-1:0]  face;
  logic [RECIP_BITS-1:0] recip;
  logic [CHG_BITS-1:0]   rem_chg;
  logic [PROD_BITS-1:0]  prod;
  logic [QF_BITS-1:0]    qf;
  logic                  take_ok, later;

  // Amounts are taken modulo 2^AMOUNT_BITS.
  assign price_ext = 32'(in_price_cents);
  assign paid_ext  = 32'(in_paid_cents);
  assign diff_full = {1'b0, paid_ext[AW-1:0]} - {1'b0, price_ext[AW-1:0]};

  // The change is the difference of two 24-bit inputs, so it always fits CHG_BITS.
  assign face    = note_face_f(3'(idx_r));
  assign recip   = note_recip_f(3'(idx_r));
  assign rem_chg = CHG_BITS'(rem_r);
  assign prod    = PROD_BITS'(rem_chg) * PROD_BITS'(recip);
  assign qf      = QF_BITS'(q_r[STOCK_BITS-1:0]) * QF_BITS'(face);
  // A quotient of 256 or more can never be in stock.
  assign take_ok = (q_r[Q_BITS-1:STOCK_BITS] == '0) && (q_r[STOCK_BITS-1:0] != '0) &&
                   (q_r[STOCK_BITS-1:0] <= stock_r[idx_r]);

  always_comb begin
    later = 1'b0;
    for (int j = 0; j < NOTE_KINDS; j++) begin
      if (IW'(j) > idx_r) begin
        later = later | took_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      short_r <= diff_full[AW];
      diff_r  <= diff_full[AW-1:0];
    end
    if (cmd.walk_init) begin
      rem_r  <= diff_r;
      idx_r  <= '0;
      ph_r   <= 1'b0;
      took_r <= '0;
    end
    if (cmd.div_step) begin
      if (!ph_r) begin
        // First cycle of a kind: register the quotient from the reciprocal product.
        q_r  <= prod[RECIP_SHIFT +: Q_BITS];
        ph_r <= 1'b1;
      end else begin
        ph_r <= 1'b0;
        if (take_ok) begin
          rem_r         <= rem_r - AW'(qf);
          took_r[idx_r] <= 1'b1;
          take_r[idx_r] <= q_r[STOCK_BITS-1:0];
        end
        if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
    if (cmd.commit_init) begin
      idx_r <= '0;
    end
    if (cmd.commit_step) begin
      if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
      out_kind_r   <= PIECE_NOTE;
      out_value_r  <= face;
      out_count_r  <= COUNT_BITS'(take_r[idx_r]);
      out_status_r <= ST_OK;
      out_last_r   <= (rem_r == '0) && !later;
    end
    if (cmd.emit_status) begin
      out_kind_r   <= PIECE_NONE;
      out_value_r  <= '0;
      out_count_r  <= '0;
      out_status_r <= cmd.status;
      out_last_r   <= 1'b1;
    end
    if (cmd.emit_coin) begin
      out_kind_r   <= PIECE_COIN;
      out_value_r  <= COIN_CENTS;
      out_count_r  <= COUNT_BITS'(1);
      out_status_r <= ST_OK;
      out_last_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTE_KINDS; i++) begin
        stock_r[i] <= STOCK_RESET;
      end
      refill_r    <= REFILL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.refill) begin
        for (int i = 0; i < NOTE_KINDS; i++) begin
          stock_r[i] <= refill_r;
        end
      end else if (cmd.commit_step && took_r[idx_r]) begin
        stock_r[idx_r] <= stock_r[idx_r] - take_r[idx_r];
      end
      if (cfg_wr) begin
        refill_r <= cfg_data;
      end
      out_valid_r <= cmd.emit_status | cmd.emit_coin | (cmd.commit_step & took_r[idx_r]);
    end
  end

  assign sts.op          = op_r;
  assign sts.short_pay   = short_r;
  assign sts.walk_last   = ph_r && (idx_r == LAST_IDX);
  assign sts.rem_gt1     = (rem_r > AW'(1));
  assign sts.rem_one     = (rem_r == AW'(1));
  assign sts.any_took    = |took_r;
  assign sts.commit_last = (idx_r == LAST_IDX);

  assign out_valid       = out_valid_r;
  assign out_piece_kind  = out_kind_r;
  assign out_value_cents = out_value_r;
  assign out_piece_count = out_count_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

// ===== hw/rtl/change_dispense_with_stock_top.sv =====
// Top level of the change dispenser with limited banknote stock.
// Instantiates cdws_ctrl and cdws_dp; uses cdws_pkg and the assertion macro header.
//
// Usage. An item (op, price, paid) is accepted at a clock edge where start is high
// and busy is low. op 0 is a sale, op 1 refills every note stock with the value last
// written on the configuration channel (cfg_valid/cfg_data, cfg_ready always high,
// reset value 5). Configuration is to be written only while the block is idle; the
// block itself does not enforce this. Results appear on the out_ ports for exactly
// one cycle each, marked by out_valid; the receiver cannot stall, so nothing waits.
// out_last marks the final result of an item. Results of one item come in order:
// notes largest first, then a one-cent coin if one cent is left, or a single
// status-only result. Flow with K note kinds walked (K = min(NOTE_KINDS, 6)): a
// refill or short payment gives its result from the decide state that follows
// acceptance. A sale takes each note kind through the divider (a multiply by the
// reciprocal of the face value, then the take decision), and a stock-short or
// exact-payment result comes from the judge state after the divider; a dispensing
// sale then walks the K kinds once more, one result register write a cycle, and
// ends in the coin state if one cent is left.
// The next item can be taken at the edge that accepts the final result.
// Reset (synchronous, active low) sets every note stock to 2 and refill count to 5.
`include "change_dispense_with_stock_top_defines.svh"

module change_dispense_with_stock_top import cdws_pkg::*; #(
  parameter int NOTE_KINDS  = 6,
  parameter int AMOUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [23:0]           in_price_cents,
  input  logic [23:0]           in_paid_cents,
  output logic                  out_valid,
  output logic [1:0]            out_piece_kind,
  output logic [FACE_BITS-1:0]  out_value_cents,
  output logic [COUNT_BITS-1:0] out_piece_count,
  output logic [1:0]            out_status,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [STOCK_BITS-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // The refill register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  cdws_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  cdws_dp #(
    .NOTE_KINDS  (NOTE_KINDS),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_price_cents  (in_price_cents),
    .in_paid_cents   (in_paid_cents),
    .cfg_wr          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_piece_kind  (out_piece_kind),
    .out_value_cents (out_value_cents),
    .out_piece_count (out_piece_count),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  // An accepted item always keeps the block busy in the following cycle.
  `CDWS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  // Any status other than ok comes alone, as a status-only final result.
  `CDWS_ASSERT_IMP(a_status_only, clk, rst_n, out_valid && (out_status != ST_OK), (out_piece_kind == PIECE_NONE) && out_last, "error status with a piece")
  // Only the one-cent coin can follow the notes, and it ends the run.
  `CDWS_ASSERT_IMP(a_coin_last, clk, rst_n, out_valid && (out_piece_kind == PIECE_COIN), (out_value_cents == COIN_CENTS) && out_last, "bad coin result")
  // The next item's first result is registered from its decide state, so it never directly follows a final result.
  `CDWS_ASSERT_NXT(a_gap_after_last, clk, rst_n, out_valid && out_last, !out_valid, "result right after last")

endmodule
